// ===== rtl/vdc_pkg.sv =====
// ----------------------------------------------------------------------------
// vdc_pkg: shared definitions for the valid-region 2D convolution block
// Sizes, configuration register codes and the records that travel between
// the line buffer cells, the window rows and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdc_pkg;

  // Geometry limits.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KMAX        = 4;
  localparam int COEF_COLS   = 4;
  localparam int KLIM        = (KMAX < COEF_COLS) ? KMAX : COEF_COLS;

  // Field widths.
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_WORD_BITS = COEF_BITS * COEF_COLS;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ROW_SUM_BITS   = PROD_BITS + $clog2(KMAX);
  localparam int SUM_BITS       = 36;
  localparam int CNT_BITS       = 10;
  localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
  localparam int DIM_BITS       = 11;
  localparam int KDIM_BITS      = 3;
  localparam int KSUM_BITS      = KDIM_BITS + 1;
  localparam int KIDX_BITS      = $clog2(COEF_COLS);
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KROWS  = 3'd2,
    REG_KCOLS  = 3'd3,
    REG_COEF0  = 3'd4,
    REG_COEF1  = 3'd5,
    REG_COEF2  = 3'd6,
    REG_COEF3  = 3'd7
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [COEF_BITS-1:0]    coef_t;
  typedef logic signed [PROD_BITS-1:0]    prod_t;
  typedef logic signed [ROW_SUM_BITS-1:0] row_sum_t;

  // Pipeline step control shared by all cells: adv moves every stage,
  // load marks that the stage feeding the cell holds a real sample.
  typedef struct packed {
    logic adv;
    logic load;
  } pipe_ctl_t;

  // What a result needs besides its sum; valid means a result is due.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [CNT_BITS-1:0] orow;
    logic [CNT_BITS-1:0] ocol;
  } res_meta_t;

  // One sample on its way down the line buffer chain. cvec collects the
  // window column: element KMAX-1 is the newest row.
  typedef struct packed {
    logic                             valid;
    logic [CNT_BITS-1:0]              row;
    logic [ADDR_BITS-1:0]             col;
    res_meta_t                        meta;
    logic [KMAX-1:0][SAMPLE_BITS-1:0] cvec;
  } line_stage_t;

endpackage

// ===== rtl/vdc_in_if.sv =====
// ----------------------------------------------------------------------------
// vdc_in_if: sample input channel
// Valid/ready channel that carries one image sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdc_in_if;
  logic             valid;
  logic             ready;
  vdc_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/vdc_out_if.sv =====
// ----------------------------------------------------------------------------
// vdc_out_if: result output channel
// Valid/ready channel that carries one convolution result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vdc_pkg::SUM_BITS-1:0] conv_sum;
  logic [vdc_pkg::CNT_BITS-1:0]        out_row;
  logic [vdc_pkg::CNT_BITS-1:0]        out_col;
  logic                                frame_last;

  modport source (output valid, output conv_sum, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input conv_sum, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

// ===== rtl/vdc_line_cell.sv =====
// ----------------------------------------------------------------------------
// vdc_line_cell: one line buffer row
// Holds one image row. Each step it returns the sample stored at the column
// and stores the sample handed in by the previous cell in its place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdc_line_cell (
  input  logic                         clk,
  input  vdc_pkg::pipe_ctl_t           ctl,
  input  logic [vdc_pkg::ADDR_BITS-1:0] addr,
  input  vdc_pkg::sample_t             wdata,
  output vdc_pkg::sample_t             rdata_r
);

  vdc_pkg::sample_t mem [vdc_pkg::MAX_WIDTH];

  // Read before write: the old row leaves as the new row comes in.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rdata_r <= mem[addr];
      if (ctl.load) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

// ===== rtl/vdc_tap_row.sv =====
// ----------------------------------------------------------------------------
// vdc_tap_row: one row of the convolution window
// Shift taps for one kernel row, a multiplier per tap and a registered sum
// of the row's products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdc_tap_row (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vdc_pkg::pipe_ctl_t                 ctl,
  input  vdc_pkg::sample_t                   din,
  input  logic [vdc_pkg::COEF_WORD_BITS-1:0] coef_word,
  input  logic                               row_on,
  input  logic [vdc_pkg::KDIM_BITS-1:0]      kc,
  output vdc_pkg::row_sum_t                  sum_r
);

  vdc_pkg::sample_t  taps_r   [vdc_pkg::KMAX];
  vdc_pkg::prod_t    prod_r   [vdc_pkg::KMAX];
  vdc_pkg::coef_t    coef_sel [vdc_pkg::KMAX];
  vdc_pkg::row_sum_t sum_nxt;

  // The kernel sits in the right-hand kc columns of the window.
  always_comb begin
    logic                           on;
    logic [vdc_pkg::KIDX_BITS-1:0]  kj;
    on = 1'b0;
    kj = '0;
    for (int c = 0; c < vdc_pkg::KMAX; c++) begin
      on = row_on && ((vdc_pkg::KSUM_BITS'(c) + {1'b0, kc}) >=
                      vdc_pkg::KSUM_BITS'(vdc_pkg::KMAX));
      kj = vdc_pkg::KIDX_BITS'(vdc_pkg::KDIM_BITS'(c) + kc -
                               vdc_pkg::KDIM_BITS'(vdc_pkg::KMAX));
      coef_sel[c] = on ? vdc_pkg::coef_t'(coef_word[kj*vdc_pkg::COEF_BITS +:
                                                    vdc_pkg::COEF_BITS])
                       : '0;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < vdc_pkg::KMAX; c++) begin
      sum_nxt = sum_nxt + vdc_pkg::ROW_SUM_BITS'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < vdc_pkg::KMAX; c++) begin
        taps_r[c] <= '0;
      end
    end else if (ctl.adv && ctl.load) begin
      for (int c = 0; c < vdc_pkg::KMAX - 1; c++) begin
        taps_r[c] <= taps_r[c+1];
      end
      taps_r[vdc_pkg::KMAX-1] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int c = 0; c < vdc_pkg::KMAX; c++) begin
        prod_r[c] <= taps_r[c] * coef_sel[c];
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/valid_2d_convolution.sv =====
// A taken sample beat passes the line stages, then the tap, product and row-sum registers, then the output register.
// Throughput: one sample per cycle; the pipeline stalls only while a result waits.
// The rate is set by the line buffer cells, one read and one write per cycle each while the pipeline advances.
// Reset (synchronous, rst_n low) clears counters, window and pipeline valids.
// ----------------------------------------------------------------------------
// valid_2d_convolution: streaming valid-region 2D cross-correlation
// Samples enter in raster order. A chain of line buffer cells delivers the
// column above each sample, a row of window cells multiplies the window by
// the Q8.8 kernel, and an adder stage forms the 36-bit result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module valid_2d_convolution (
  input  logic                                 clk,
  input  logic                                 rst_n,
  vdc_in_if.sink                               in_bus,
  vdc_out_if.source                            out_bus,
  input  logic                                 cfg_we,
  input  logic [vdc_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [vdc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. Values outside the legal range are clamped
  // where they are used, so the raw value is kept as written.
  // --------------------------------------------------------------------------
  logic [vdc_pkg::DIM_BITS-1:0]                             cfg_width_r;
  logic [vdc_pkg::DIM_BITS-1:0]                             cfg_height_r;
  logic [vdc_pkg::KDIM_BITS-1:0]                            cfg_krows_r;
  logic [vdc_pkg::KDIM_BITS-1:0]                            cfg_kcols_r;
  logic [vdc_pkg::COEF_COLS-1:0][vdc_pkg::COEF_WORD_BITS-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= vdc_pkg::DIM_BITS'(vdc_pkg::MAX_WIDTH);
      cfg_height_r <= vdc_pkg::DIM_BITS'(vdc_pkg::MAX_HEIGHT);
      cfg_krows_r  <= vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM);
      cfg_kcols_r  <= vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM);
      coef_r       <= '0;
    end else if (cfg_we) begin
      unique case (vdc_pkg::cfg_reg_t'(cfg_idx))
        vdc_pkg::REG_WIDTH:  cfg_width_r  <= cfg_data[vdc_pkg::DIM_BITS-1:0];
        vdc_pkg::REG_HEIGHT: cfg_height_r <= cfg_data[vdc_pkg::DIM_BITS-1:0];
        vdc_pkg::REG_KROWS:  cfg_krows_r  <= cfg_data[vdc_pkg::KDIM_BITS-1:0];
        vdc_pkg::REG_KCOLS:  cfg_kcols_r  <= cfg_data[vdc_pkg::KDIM_BITS-1:0];
        vdc_pkg::REG_COEF0:  coef_r[0]    <= cfg_data;
        vdc_pkg::REG_COEF1:  coef_r[1]    <= cfg_data;
        vdc_pkg::REG_COEF2:  coef_r[2]    <= cfg_data;
        vdc_pkg::REG_COEF3:  coef_r[3]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective geometry: zero counts as one, anything above the limit
  // saturates at the limit.
  logic [vdc_pkg::DIM_BITS-1:0]  w_eff;
  logic [vdc_pkg::DIM_BITS-1:0]  h_eff;
  logic [vdc_pkg::KDIM_BITS-1:0] kr_eff;
  logic [vdc_pkg::KDIM_BITS-1:0] kc_eff;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = vdc_pkg::DIM_BITS'(1);
    end else if (cfg_width_r > vdc_pkg::DIM_BITS'(vdc_pkg::MAX_WIDTH)) begin
      w_eff = vdc_pkg::DIM_BITS'(vdc_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg_width_r;
    end
    if (cfg_height_r == '0) begin
      h_eff = vdc_pkg::DIM_BITS'(1);
    end else if (cfg_height_r > vdc_pkg::DIM_BITS'(vdc_pkg::MAX_HEIGHT)) begin
      h_eff = vdc_pkg::DIM_BITS'(vdc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_r;
    end
    if (cfg_krows_r == '0) begin
      kr_eff = vdc_pkg::KDIM_BITS'(1);
    end else if (cfg_krows_r > vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM)) begin
      kr_eff = vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM);
    end else begin
      kr_eff = cfg_krows_r;
    end
    if (cfg_kcols_r == '0) begin
      kc_eff = vdc_pkg::KDIM_BITS'(1);
    end else if (cfg_kcols_r > vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM)) begin
      kc_eff = vdc_pkg::KDIM_BITS'(vdc_pkg::KLIM);
    end else begin
      kc_eff = cfg_kcols_r;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. All stages move together; the pipeline steps whenever the
  // output register is empty or its beat is being taken, so a new sample is
  // accepted in the same cycle as a waiting result leaves.
  // --------------------------------------------------------------------------
  logic               out_valid_r;
  logic               adv;
  logic               in_acc;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_acc       = in_bus.valid && adv;

  // --------------------------------------------------------------------------
  // Raster position of the next sample, and what its result will carry.
  // --------------------------------------------------------------------------
  logic [vdc_pkg::CNT_BITS-1:0] col_cnt_r;
  logic [vdc_pkg::CNT_BITS-1:0] row_cnt_r;
  logic [vdc_pkg::DIM_BITS-1:0] col_p1;
  logic [vdc_pkg::DIM_BITS-1:0] row_p1;
  logic                         row_end;
  logic                         frame_end;
  logic                         emit;

  assign col_p1    = vdc_pkg::DIM_BITS'(col_cnt_r) + vdc_pkg::DIM_BITS'(1);
  assign row_p1    = vdc_pkg::DIM_BITS'(row_cnt_r) + vdc_pkg::DIM_BITS'(1);
  assign row_end   = col_p1 >= w_eff;
  assign frame_end = row_p1 >= h_eff;
  assign emit      = (row_p1 >= vdc_pkg::DIM_BITS'(kr_eff)) &&
                     (col_p1 >= vdc_pkg::DIM_BITS'(kc_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= frame_end ? '0 : row_p1[vdc_pkg::CNT_BITS-1:0];
      end else begin
        col_cnt_r <= col_p1[vdc_pkg::CNT_BITS-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer chain. Stage k feeds cell k+1, which returns the sample
  // k+1 rows above and stores the one handed down from the cell before it.
  // Each returned sample joins the column record one stage later.
  // --------------------------------------------------------------------------
  vdc_pkg::line_stage_t st_r   [vdc_pkg::KMAX];
  vdc_pkg::line_stage_t st_nxt [vdc_pkg::KMAX];
  vdc_pkg::sample_t     lb_rd  [vdc_pkg::KMAX-1];
  vdc_pkg::pipe_ctl_t   lb_ctl [vdc_pkg::KMAX-1];

  always_comb begin
    st_nxt[0]                       = '0;
    st_nxt[0].valid                 = in_acc;
    st_nxt[0].row                   = row_cnt_r;
    st_nxt[0].col                   = vdc_pkg::ADDR_BITS'(col_cnt_r);
    st_nxt[0].meta.valid            = emit;
    st_nxt[0].meta.last             = frame_end && row_end;
    st_nxt[0].meta.orow             = vdc_pkg::CNT_BITS'(row_p1 -
                                        vdc_pkg::DIM_BITS'(kr_eff));
    st_nxt[0].meta.ocol             = vdc_pkg::CNT_BITS'(col_p1 -
                                        vdc_pkg::DIM_BITS'(kc_eff));
    st_nxt[0].cvec[vdc_pkg::KMAX-1] = in_bus.sample;
  end

  for (genvar k = 1; k < vdc_pkg::KMAX; k++) begin : g_line
    if (k == 1) begin : g_first
      always_comb begin
        st_nxt[k] = st_r[k-1];
      end
      assign lb_ctl[k-1] = '{adv: adv, load: st_r[k-1].valid};
      vdc_line_cell u_cell (
        .clk     (clk),
        .ctl     (lb_ctl[k-1]),
        .addr    (st_r[k-1].col),
        .wdata   (vdc_pkg::sample_t'(st_r[k-1].cvec[vdc_pkg::KMAX-1])),
        .rdata_r (lb_rd[k-1])
      );
    end else begin : g_next
      always_comb begin
        st_nxt[k]                   = st_r[k-1];
        st_nxt[k].cvec[vdc_pkg::KMAX-k] = lb_rd[k-2];
      end
      assign lb_ctl[k-1] = '{adv: adv, load: st_r[k-1].valid};
      vdc_line_cell u_cell (
        .clk     (clk),
        .ctl     (lb_ctl[k-1]),
        .addr    (st_r[k-1].col),
        .wdata   (lb_rd[k-2]),
        .rdata_r (lb_rd[k-1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < vdc_pkg::KMAX; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < vdc_pkg::KMAX; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Window column. The oldest row comes straight from the last cell. Rows
  // that lie above the top of the frame enter the window as zero.
  // --------------------------------------------------------------------------
  vdc_pkg::sample_t win_col [vdc_pkg::KMAX];

  always_comb begin
    vdc_pkg::sample_t src;
    src = '0;
    for (int r = 0; r < vdc_pkg::KMAX; r++) begin
      src = (r == 0) ? lb_rd[vdc_pkg::KMAX-2]
                     : vdc_pkg::sample_t'(st_r[vdc_pkg::KMAX-1].cvec[r]);
      win_col[r] = ((vdc_pkg::DIM_BITS'(st_r[vdc_pkg::KMAX-1].row) +
                     vdc_pkg::DIM_BITS'(r)) >= vdc_pkg::DIM_BITS'(vdc_pkg::KMAX-1))
                   ? src : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Window rows. The kernel occupies the bottom kr rows of the window; each
  // row cell gets its coefficient word and whether it is in use.
  // --------------------------------------------------------------------------
  vdc_pkg::pipe_ctl_t                 win_ctl;
  logic [vdc_pkg::COEF_WORD_BITS-1:0] row_coef [vdc_pkg::KMAX];
  logic [vdc_pkg::KMAX-1:0]           row_on;
  vdc_pkg::row_sum_t                  row_sum  [vdc_pkg::KMAX];

  assign win_ctl = '{adv: adv, load: st_r[vdc_pkg::KMAX-1].valid};

  always_comb begin
    logic [vdc_pkg::KIDX_BITS-1:0] ki;
    ki = '0;
    for (int r = 0; r < vdc_pkg::KMAX; r++) begin
      row_on[r]   = (vdc_pkg::KSUM_BITS'(r) + {1'b0, kr_eff}) >=
                    vdc_pkg::KSUM_BITS'(vdc_pkg::KMAX);
      ki          = vdc_pkg::KIDX_BITS'(vdc_pkg::KDIM_BITS'(r) + kr_eff -
                                        vdc_pkg::KDIM_BITS'(vdc_pkg::KMAX));
      row_coef[r] = coef_r[ki];
    end
  end

  for (genvar r = 0; r < vdc_pkg::KMAX; r++) begin : g_row
    vdc_tap_row u_row (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (win_ctl),
      .din       (win_col[r]),
      .coef_word (row_coef[r]),
      .row_on    (row_on[r]),
      .kc        (kc_eff),
      .sum_r     (row_sum[r])
    );
  end

  // --------------------------------------------------------------------------
  // Result side. The metadata follows the window through the product and
  // row-sum stages; samples that give no result drop out here.
  // --------------------------------------------------------------------------
  vdc_pkg::res_meta_t w_r;
  vdc_pkg::res_meta_t p_r;
  vdc_pkg::res_meta_t s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.valid <= 1'b0;
      p_r.valid <= 1'b0;
      s_r.valid <= 1'b0;
    end else if (adv) begin
      w_r       <= st_r[vdc_pkg::KMAX-1].meta;
      w_r.valid <= st_r[vdc_pkg::KMAX-1].valid && st_r[vdc_pkg::KMAX-1].meta.valid;
      p_r       <= w_r;
      s_r       <= p_r;
    end
  end

  logic signed [vdc_pkg::SUM_BITS-1:0] total;

  always_comb begin
    total = '0;
    for (int r = 0; r < vdc_pkg::KMAX; r++) begin
      total = total + vdc_pkg::SUM_BITS'(row_sum[r]);
    end
  end

  logic signed [vdc_pkg::SUM_BITS-1:0] out_sum_r;
  logic [vdc_pkg::CNT_BITS-1:0]        out_row_r;
  logic [vdc_pkg::CNT_BITS-1:0]        out_col_r;
  logic                                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sum_r  <= total;
      out_row_r  <= s_r.orow;
      out_col_r  <= s_r.ocol;
      out_last_r <= s_r.last;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.conv_sum   = out_sum_r;
  assign out_bus.out_row    = out_row_r;
  assign out_bus.out_col    = out_col_r;
  assign out_bus.frame_last = out_last_r;

  // Valid bits of every stage before the output register, gathered for checking.
  logic [vdc_pkg::KMAX+2:0] pipe_vld;

  always_comb begin
    for (int k = 0; k < vdc_pkg::KMAX; k++) begin
      pipe_vld[k] = st_r[k].valid;
    end
    pipe_vld[vdc_pkg::KMAX]   = w_r.valid;
    pipe_vld[vdc_pkg::KMAX+1] = p_r.valid;
    pipe_vld[vdc_pkg::KMAX+2] = s_r.valid;
  end

`ifndef NO_ASSERTIONS
  // Reset leaves the raster position at the top-left corner.
  a_reset_pos: assert property (@(posedge clk)
    !rst_n |=> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("raster position not cleared by reset");

  // A stalled pipeline keeps every stage where it is.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pipe_vld))
    else $error("pipeline stage moved during a stall");

  // Inside a row the column advances by exactly one per accepted beat.
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !row_end) |=> (col_cnt_r == $past(col_cnt_r) + 10'd1))
    else $error("column counter did not step by one");

  // A result only appears when the row-sum stage held one.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s_r.valid))
    else $error("result beat without a matching pipeline entry");
`endif

endmodule
